// ----- rtl/core/pdt_pkg.sv -----
// pdt_pkg: shared types and constants of the periodic task dispatcher
// command codes, decoded job record passed from front to back
// no dependencies
package pdt_pkg;

    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;
    localparam int MAX_SLOTS  = 8;

    localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARREST     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTINUE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ARREST_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCAN       = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_ARREST,
        OP_CONTINUE,
        OP_ARREST_ALL,
        OP_SCAN
    } op_t;

    // value carries the period for add and the current time for scan
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] value;
    } job_t;

endpackage

// ----- rtl/core/pdt_front.sv -----
// pdt_front: command intake of the periodic task dispatcher
// decodes each command transfer into a job and queues it in a two-entry fifo
// depends on pdt_pkg
module pdt_front
    import pdt_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // command, slot, period, now, zero fill
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    localparam int QDEPTH = 2;

    job_t              queue_reg [QDEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
    logic              slot_ok;
    job_t              dec;
    logic              push;
    logic              pop;

    assign cmd    = s_tdata[CMD_W-1:0];
    assign slot   = s_tdata[CMD_W+SLOT_W-1:CMD_W];
    assign period = s_tdata[CMD_W+SLOT_W+TIME_W-1:CMD_W+SLOT_W];
    assign now    = s_tdata[CMD_W+SLOT_W+2*TIME_W-1:CMD_W+SLOT_W+TIME_W];

    assign slot_ok = int'(slot) < TASK_SLOTS;

    always_comb
    begin
        dec.slot  = slot;
        dec.value = period;
        case (cmd)
            CMD_ADD:        dec.op = slot_ok ? OP_ADD : OP_NOP;
            CMD_ARREST:     dec.op = slot_ok ? OP_ARREST : OP_NOP;
            CMD_CONTINUE:   dec.op = slot_ok ? OP_CONTINUE : OP_NOP;
            CMD_ARREST_ALL: dec.op = OP_ARREST_ALL;
            CMD_SCAN:
            begin
                dec.op    = OP_SCAN;
                dec.value = now;
            end
            default:        dec.op = OP_NOP;
        endcase
    end

    assign s_tready  = (count_reg != 2'(QDEPTH));
    assign job_valid = (count_reg != 2'd0);
    assign job       = queue_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- rtl/core/pdt_back.sv -----
// pdt_back: execution side of the periodic task dispatcher
// holds the slot tables, applies jobs and walks the slots one per cycle on scan while the output is not stalled
// depends on pdt_pkg
module pdt_back
    import pdt_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  job_t                  job,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // task_index, zero fill
    output logic                  m_tlast
);

    // slots past the 3-bit slot field can never be reached
    localparam int NSLOT = (TASK_SLOTS < MAX_SLOTS) ? TASK_SLOTS : MAX_SLOTS;
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NSLOT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] period_reg [NSLOT];
    logic [TIME_W-1:0] period_next [NSLOT];
    logic [TIME_W-1:0] last_reg [NSLOT];
    logic [TIME_W-1:0] last_next [NSLOT];
    logic [NSLOT-1:0]  active_reg;
    logic [NSLOT-1:0]  active_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [IW-1:0]     pend_index_reg;
    logic [IW-1:0]     pend_index_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SLOT_W-1:0] out_index_reg;
    logic [SLOT_W-1:0] out_index_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              out_free;
    logic              hit;
    logic [TIME_W-1:0] elapsed;
    logic [IW-1:0]     job_slot;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign elapsed   = now_reg - last_reg[idx_reg];
    assign hit       = active_reg[idx_reg] && (period_reg[idx_reg] < elapsed);
    assign job_slot  = job.slot[IW-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-SLOT_W){1'b0}}, out_index_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        period_next     = period_reg;
        last_next       = last_reg;
        active_next     = active_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    case (job.op)
                        OP_ADD:
                        begin
                            period_next[job_slot] = job.value;
                            active_next[job_slot] = 1'b1;
                        end
                        OP_ARREST:     active_next[job_slot] = 1'b0;
                        OP_CONTINUE:   active_next[job_slot] = 1'b1;
                        OP_ARREST_ALL: active_next = '0;
                        OP_SCAN:
                        begin
                            now_next   = job.value;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // a due slot is held back in the pending register so the final one can carry tlast
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        last_next[idx_reg] = now_reg;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = SLOT_W'(pend_index_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = SLOT_W'(pend_index_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < NSLOT; i++)
            begin
                period_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
            active_reg     <= '0;
            now_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            period_reg     <= period_next;
            last_reg       <= last_next;
            active_reg     <= active_next;
            now_reg        <= now_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_index_reg <= pend_index_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ----- rtl/core/periodic_task_dispatcher.sv -----
// periodic_task_dispatcher: top level of the periodic task dispatcher
// joins the command front end and the slot execution back end
// depends on pdt_pkg, pdt_front, pdt_back
//
// usage
// - commands arrive on the s_ channel: add, arrest, continue, arrest all, scan
// - each scan transfer yields one m_ transfer per due slot in ascending order,
//   m_tdata holds the slot index and m_tlast marks the final due slot of the scan
// - a scan with no due slot, and every other command, yields no output transfer
// - a two-entry queue sits between intake and execution, so commands are taken
//   while the back end is busy until the queue is full
// - add, arrest, continue and arrest all are applied by the back end while it is idle
// - a scan walks min(TASK_SLOTS, 8) slots, one slot compared per cycle while the
//   output is not stalled, in the single subtract and compare unit that walks the slots
// - first output transfer follows a scan transfer through the queue, the pending register and the output register
// - when the receiver stalls, the slot walk holds at the next due slot and the
//   queue fills, after which s_tready drops
// - reset clears all periods, last-fired times and active flags, and empties
//   the queue and the output register
module periodic_task_dispatcher
    import pdt_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // command, slot, period, now, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // task_index, zero fill
    output logic                  m_tlast
);

    logic job_valid;
    logic job_ready;
    job_t job;

    pdt_front #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    pdt_back #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- sim/periodic_task_dispatcher_test.sv -----
// periodic_task_dispatcher_test: self-checking bench for the periodic task dispatcher
// a directed table and a random command stream are checked against a slot-table predictor
// depends on pdt_pkg and periodic_task_dispatcher
`timescale 1ns / 100ps

module periodic_task_dispatcher_test;
    import pdt_pkg::*;

    localparam int SLOTS       = 8;
    localparam int PLAN_LEN    = 25;
    localparam int RANDOM_CMDS = 190;
    localparam int LONG_STALL  = 150;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 30;

    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] index;
        logic              last;
    } due_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] now;
        logic              fixed;
        logic [SLOTS-1:0]  fixed_due;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // command, slot, period, now, zero fill
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // task_index, zero fill
    logic                  m_tlast;

    logic [TIME_W-1:0] slot_period [SLOTS];
    logic [TIME_W-1:0] slot_last   [SLOTS];
    logic [SLOTS-1:0]  slot_live;
    due_t              due_q [$];

    int unsigned fail_count;
    int unsigned cmds_sent;
    int unsigned scans_sent;
    int unsigned results_seen;
    int unsigned burst_left;
    int unsigned stall_request;

    stim_row_t plan [PLAN_LEN] = '{
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00},
        '{CMD_ADD,        3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0001, 1'b1, 8'h01},
        '{CMD_ADD,        3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_ADD,        3'd3, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0010, 1'b0, 8'h00},
        '{CMD_ARREST,     3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0020, 1'b0, 8'h00},
        '{CMD_CONTINUE,   3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0030, 1'b0, 8'h00},
        '{CMD_SPARE5,     3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h00},
        '{CMD_SPARE7,     3'd7, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 8'h00},
        '{CMD_CONTINUE,   3'd1, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_CONTINUE,   3'd2, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_ADD,        3'd3, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_CONTINUE,   3'd4, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_CONTINUE,   3'd5, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_CONTINUE,   3'd6, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_ADD,        3'd7, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0000_0040, 1'b0, 8'h00},
        '{CMD_ARREST_ALL, 3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
        '{CMD_SCAN,       3'd0, 32'h0000_0000, 32'h0012_3456, 1'b1, 8'h00}
    };

    periodic_task_dispatcher #(
        .TASK_SLOTS(SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // updates the slot table and returns the set of slots fired by a scan
    function automatic logic [SLOTS-1:0] run_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [TIME_W-1:0] period,
                                                     input logic [TIME_W-1:0] now);
        logic [SLOTS-1:0]  fired;
        logic [TIME_W-1:0] elapsed;
        fired = '0;
        case (cmd)
            CMD_ADD:
            begin
                slot_period[slot] = period;
                slot_live[slot]   = 1'b1;
            end
            CMD_ARREST:     slot_live[slot] = 1'b0;
            CMD_CONTINUE:   slot_live[slot] = 1'b1;
            CMD_ARREST_ALL: slot_live = '0;
            CMD_SCAN:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    elapsed = now - slot_last[i];
                    if (slot_live[i] && slot_period[i] < elapsed)
                    begin
                        fired[i]     = 1'b1;
                        slot_last[i] = now;
                    end
                end
            end
            default: ;
        endcase
        return fired;
    endfunction

    task automatic queue_due(input logic [SLOTS-1:0] fired);
        due_t entry;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (fired[i])
            begin
                entry.index = i[SLOT_W-1:0];
                entry.last  = ((fired >> (i + 1)) == '0);
                due_q.push_back(entry);
            end
        end
    endtask

    // sender pacing: bursts of random length separated by random gaps
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // offers one command and returns at the edge where the transfer happens
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, now, period, slot, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cmds_sent++;
        if (cmd == CMD_SCAN)
            scans_sent++;
    endtask

    initial
    begin
        #2_000_000;
        $display("FAIL periodic_task_dispatcher");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                stall_left = stall_request;
                stall_request <= 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 40);
            end
            mode_left--;
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 4) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        due_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual index %0d last %0b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = due_q.pop_front();
                if (m_tdata !== {{(OUT_DATA_W - SLOT_W){1'b0}}, want.index} ||
                    m_tlast !== want.last)
                begin
                    $display("%0t: mismatch, expected index %0d last %0b, actual data %0d last %0b",
                             $time, want.index, want.last, m_tdata, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [SLOTS-1:0]  fired;
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] ticks;
        int unsigned       pick;
        int unsigned       counted;
        int unsigned       guard;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        fail_count    = 0;
        cmds_sent     = 0;
        scans_sent    = 0;
        results_seen  = 0;
        burst_left    = 0;
        stall_request = 0;
        slot_live     = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_period[i] = '0;
            slot_last[i]   = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            pace_sender();
            send_command(plan[r].cmd, plan[r].slot, plan[r].period, plan[r].now);
            fired = run_command(plan[r].cmd, plan[r].slot, plan[r].period, plan[r].now);
            queue_due(plan[r].fixed ? plan[r].fixed_due : fired);
        end

        ticks   = 32'h0000_0100;
        counted = 0;
        while (counted < RANDOM_CMDS)
        begin
            pick   = $urandom_range(0, 99);
            slot   = SLOT_W'($urandom_range(0, SLOTS - 1));
            period = $urandom;
            now    = $urandom;
            if (pick < 35)
            begin
                cmd = CMD_SCAN;
                if ($urandom_range(0, 19) == 0)
                    ticks = $urandom;
                else
                    ticks = ticks + $urandom_range(0, 40);
                now = ticks;
            end
            else if (pick < 65)
            begin
                cmd = CMD_ADD;
                if ($urandom_range(0, 9) != 0)
                    period = $urandom_range(0, 60);
            end
            else if (pick < 80)
                cmd = CMD_ARREST;
            else if (pick < 92)
                cmd = CMD_CONTINUE;
            else if (pick < 95)
                cmd = CMD_ARREST_ALL;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_SPARE5;
                    1:       cmd = CMD_SPARE6;
                    default: cmd = CMD_SPARE7;
                endcase
            end

            if (counted == 70)
                stall_request <= LONG_STALL;
            if (counted == 150)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (due_q.size() != 0)
                    @(posedge clk);
            end

            pace_sender();
            send_command(cmd, slot, period, now);
            fired = run_command(cmd, slot, period, now);
            queue_due(fired);
            if (cmd <= CMD_SCAN)
                counted++;
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (due_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (due_q.size() != 0)
        begin
            $display("%0t: %0d due-task transfers never arrived, oldest expected index %0d last %0b",
                     $time, due_q.size(), due_q[0].index, due_q[0].last);
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d commands including %0d scans, %0d due-task transfers checked",
                 cmds_sent, scans_sent, results_seen);
        $display("receiver held off %0d cycles once, %0d failures", LONG_STALL, fail_count);
        if (fail_count == 0)
            $display("PASS periodic_task_dispatcher");
        else
            $display("FAIL periodic_task_dispatcher");
        $finish;
    end

endmodule
